@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define FSA_CHECK(label, clk, rstn, cond) \
	label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("assertion failed");

// Check a condition in the cycle after a trigger.
`define FSA_NEXT(label, clk, rstn, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
		else $error("assertion failed");

`endif

@@ design/fsa_pkg.sv @@
`default_nettype none
package fsa_pkg;
	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_BITS   = 32;
	localparam int FIELD_W     = 32;
	localparam int CFG_IDX_W   = 2;

	typedef logic [1:0] status_t;
	localparam status_t ST_DONE    = 2'd0;
	localparam status_t ST_NO_FIT  = 2'd1;
	localparam status_t ST_FULL    = 2'd2;

	typedef logic [1:0] policy_t;
	localparam policy_t POL_FIRST = 2'd0;
	localparam policy_t POL_BEST  = 2'd1;
	localparam policy_t POL_NEXT  = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_POLICY      = 2'd0;
	localparam cfg_idx_t CFG_HEAP_START  = 2'd1;
	localparam cfg_idx_t CFG_HEAP_LENGTH = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;
endpackage
`default_nettype wire

@@ design/fsa_ifs.sv @@
`default_nettype none
interface fsa_req_if;
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic [fsa_pkg::FIELD_W-1:0]  request_size;
	logic [fsa_pkg::FIELD_W-1:0]  free_address;
	modport source (output valid, command, request_size, free_address, input ready);
	modport sink (input valid, command, request_size, free_address, output ready);
endinterface

interface fsa_rsp_if;
	logic                         valid;
	logic                         ready;
	fsa_pkg::status_t             status;
	logic [fsa_pkg::FIELD_W-1:0]  address;
	modport source (output valid, status, address, input ready);
	modport sink (input valid, status, address, output ready);
endinterface
`default_nettype wire

@@ design/free_segment_allocator_core.sv @@
// An allocate scans the table one entry at a time, picks a segment, then takes it;
// on an exact fit the entries behind it are moved down one place each.
// A free scans up to its place, then merges with neighbors or moves the entries up.
// One request at a time: a new one is taken only in idle, once the last response is placed,
// and each pass is paced by the single read port of the segment table memory.
// Reset: async, empty table, registers zero; no clearing pass (fill count guards reads).
`default_nettype none
`include "assert_macros.svh"
module free_segment_allocator_core #(
	parameter int TABLE_DEPTH = fsa_pkg::TABLE_DEPTH,
	parameter int ADDR_BITS   = fsa_pkg::ADDR_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write_en,
	input  wire fsa_pkg::cfg_idx_t             cfg_index,
	input  wire logic [fsa_pkg::FIELD_W-1:0]   cfg_data,
	fsa_req_if.sink                            req,
	fsa_rsp_if.source                          rsp
);
	localparam int AW = ADDR_BITS;
	localparam int FW = fsa_pkg::FIELD_W;
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef struct packed {
		logic [AW-1:0] start;
		logic [AW-1:0] len;
	} seg_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_EV, S_ADEC, S_AGET, S_SHD_RD, S_SHD_WR,
		S_FDEC, S_FSUM, S_SHU_RD, S_SHU_WR, S_RESP
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q, i_q, j_q;
	logic [AW-1:0]       last_q, size_q, addr_q, end_q, acc_q, res_q, bt_len_q;
	fsa_pkg::policy_t    policy_q;
	logic [FW-1:0]       heap_start_q, heap_len_q;
	logic                cmd_q;
	fsa_pkg::status_t    status_q;
	logic                ff_hit_q, ex_hit_q, bt_hit_q, nx_hit_q;
	logic [IW-1:0]       ff_idx_q, ex_idx_q, bt_idx_q, nx_idx_q, sel_q;
	seg_t                prev_q, cur_q;
	logic                rsp_valid_q;
	fsa_pkg::status_t    rsp_status_q;
	logic [FW-1:0]       rsp_addr_q;

	seg_t                seg_mem [TABLE_DEPTH];
	seg_t                rd_q;
	logic                mem_we;
	logic [IW-1:0]       mem_waddr, mem_raddr;
	seg_t                mem_wdata;

	logic                sel_hit;
	logic [IW-1:0]       sel_idx;
	logic [AW-1:0]       prev_end, prev_sum;
	logic                join_prev, join_next, cfg_reload;

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.address  = rsp_addr_q;

	assign cfg_reload = cfg_write_en && (cfg_index == fsa_pkg::CFG_HEAP_START ||
		cfg_index == fsa_pkg::CFG_HEAP_LENGTH);

	// Pick the segment that the policy asks for
	always_comb begin
		sel_hit = ff_hit_q;
		sel_idx = ff_idx_q;
		case (policy_q)
			fsa_pkg::POL_BEST: begin
				sel_hit = ex_hit_q || bt_hit_q;
				sel_idx = ex_hit_q ? ex_idx_q : bt_idx_q;
			end
			fsa_pkg::POL_NEXT: begin
				if (nx_hit_q) begin
					sel_hit = 1'b1;
					sel_idx = nx_idx_q;
				end
			end
			default: ;
		endcase
	end

	// Merge tests on the neighbors of a freed segment
	assign prev_end  = prev_q.start + prev_q.len;
	assign prev_sum  = prev_q.len + size_q;
	assign join_prev = (i_q != '0) && (prev_end == addr_q);
	assign join_next = (i_q != count_q) && (cur_q.start == end_q);

	// Drive the table ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = IW'(i_q);
		if (cfg_reload) begin
			mem_we    = 1'b1;
			mem_wdata.start = (cfg_index == fsa_pkg::CFG_HEAP_START) ?
				AW'(cfg_data) : AW'(heap_start_q);
			mem_wdata.len   = (cfg_index == fsa_pkg::CFG_HEAP_LENGTH) ?
				AW'(cfg_data) : AW'(heap_len_q);
		end else begin
			case (state_q)
				S_ADEC: mem_raddr = sel_idx;
				S_AGET: begin
					if (rd_q.len != size_q) begin
						mem_we          = 1'b1;
						mem_waddr       = sel_q;
						mem_wdata.start = rd_q.start + size_q;
						mem_wdata.len   = rd_q.len - size_q;
					end
				end
				S_SHD_RD: mem_raddr = IW'(j_q);
				S_SHD_WR: begin
					mem_we    = 1'b1;
					mem_waddr = IW'(j_q - 1'b1);
					mem_wdata = rd_q;
				end
				S_FDEC: begin
					if (join_prev && !join_next) begin
						mem_we          = 1'b1;
						mem_waddr       = IW'(i_q - 1'b1);
						mem_wdata.start = prev_q.start;
						mem_wdata.len   = prev_sum;
					end else if (join_next && !join_prev) begin
						mem_we          = 1'b1;
						mem_waddr       = IW'(i_q);
						mem_wdata.start = addr_q;
						mem_wdata.len   = cur_q.len + size_q;
					end
				end
				S_FSUM: begin
					mem_we          = 1'b1;
					mem_waddr       = IW'(i_q - 1'b1);
					mem_wdata.start = prev_q.start;
					mem_wdata.len   = acc_q + cur_q.len;
				end
				S_SHU_RD: begin
					if (j_q == i_q) begin
						mem_we          = 1'b1;
						mem_waddr       = IW'(i_q);
						mem_wdata.start = addr_q;
						mem_wdata.len   = size_q;
					end else begin
						mem_raddr = IW'(j_q - 1'b1);
					end
				end
				S_SHU_WR: begin
					mem_we    = 1'b1;
					mem_waddr = IW'(j_q);
					mem_wdata = rd_q;
				end
				default: ;
			endcase
		end
	end

	// Segment table memory
	always_ff @(posedge clk) begin
		if (mem_we)
			seg_mem[mem_waddr] <= mem_wdata;
		rd_q <= seg_mem[mem_raddr];
	end

	// Sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			last_q       <= '0;
			size_q       <= '0;
			addr_q       <= '0;
			end_q        <= '0;
			acc_q        <= '0;
			res_q        <= '0;
			bt_len_q     <= '0;
			policy_q     <= fsa_pkg::POL_FIRST;
			heap_start_q <= '0;
			heap_len_q   <= '0;
			cmd_q        <= fsa_pkg::CMD_ALLOC;
			status_q     <= fsa_pkg::ST_DONE;
			ff_hit_q     <= 1'b0;
			ex_hit_q     <= 1'b0;
			bt_hit_q     <= 1'b0;
			nx_hit_q     <= 1'b0;
			ff_idx_q     <= '0;
			ex_idx_q     <= '0;
			bt_idx_q     <= '0;
			nx_idx_q     <= '0;
			sel_q        <= '0;
			prev_q       <= '0;
			cur_q        <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= fsa_pkg::ST_DONE;
			rsp_addr_q   <= '0;
		end else begin
			// drop the taken word unless the response state replaces it
			if (rsp.valid && rsp.ready && state_q != S_RESP)
				rsp_valid_q <= 1'b0;

			// Take configuration writes; heap writes reload the table
			if (cfg_write_en) begin
				case (cfg_index)
					fsa_pkg::CFG_POLICY: begin
						policy_q <= cfg_data[1:0];
					end
					fsa_pkg::CFG_HEAP_START: begin
						heap_start_q <= cfg_data;
						count_q      <= CW'(AW'(heap_len_q) != '0);
						last_q       <= '0;
					end
					fsa_pkg::CFG_HEAP_LENGTH: begin
						heap_len_q <= cfg_data;
						count_q    <= CW'(AW'(cfg_data) != '0);
						last_q     <= '0;
					end
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q    <= req.command;
						size_q   <= AW'(req.request_size);
						addr_q   <= AW'(req.free_address);
						end_q    <= AW'(req.free_address) + AW'(req.request_size);
						i_q      <= '0;
						res_q    <= '0;
						ff_hit_q <= 1'b0;
						ex_hit_q <= 1'b0;
						bt_hit_q <= 1'b0;
						nx_hit_q <= 1'b0;
						status_q <= fsa_pkg::ST_DONE;
						if (AW'(req.request_size) == '0) begin
							status_q <= (req.command == fsa_pkg::CMD_FREE) ?
								fsa_pkg::ST_DONE : fsa_pkg::ST_NO_FIT;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					if (i_q == count_q)
						state_q <= (cmd_q == fsa_pkg::CMD_FREE) ? S_FDEC : S_ADEC;
					else
						state_q <= S_SCAN_EV;
				end
				S_SCAN_EV: begin
					if (cmd_q == fsa_pkg::CMD_FREE) begin
						// stop at the first entry at or above the freed address
						if (rd_q.start >= addr_q) begin
							cur_q   <= rd_q;
							state_q <= S_FDEC;
						end else begin
							prev_q  <= rd_q;
							i_q     <= i_q + 1'b1;
							state_q <= S_SCAN_RD;
						end
					end else begin
						if (!ff_hit_q && rd_q.len >= size_q) begin
							ff_hit_q <= 1'b1;
							ff_idx_q <= IW'(i_q);
						end
						if (!ex_hit_q && rd_q.len == size_q) begin
							ex_hit_q <= 1'b1;
							ex_idx_q <= IW'(i_q);
						end
						if (rd_q.len > size_q && (!bt_hit_q || rd_q.len < bt_len_q)) begin
							bt_hit_q <= 1'b1;
							bt_idx_q <= IW'(i_q);
							bt_len_q <= rd_q.len;
						end
						if (!nx_hit_q && rd_q.len >= size_q && rd_q.start > last_q) begin
							nx_hit_q <= 1'b1;
							nx_idx_q <= IW'(i_q);
						end
						i_q     <= i_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_ADEC: begin
					sel_q <= sel_idx;
					if (sel_hit) begin
						state_q <= S_AGET;
					end else begin
						status_q <= fsa_pkg::ST_NO_FIT;
						state_q  <= S_RESP;
					end
				end
				S_AGET: begin
					res_q  <= rd_q.start;
					last_q <= rd_q.start;
					if (rd_q.len == size_q) begin
						j_q     <= CW'(sel_q) + 1'b1;
						state_q <= S_SHD_RD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_SHD_RD: begin
					if (j_q == count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_RESP;
					end else begin
						state_q <= S_SHD_WR;
					end
				end
				S_SHD_WR: begin
					j_q     <= j_q + 1'b1;
					state_q <= S_SHD_RD;
				end
				S_FDEC: begin
					if (join_prev && join_next) begin
						acc_q   <= prev_sum;
						state_q <= S_FSUM;
					end else if (join_prev || join_next) begin
						state_q <= S_RESP;
					end else if (count_q == CW'(TABLE_DEPTH)) begin
						status_q <= fsa_pkg::ST_FULL;
						state_q  <= S_RESP;
					end else begin
						j_q     <= count_q;
						state_q <= S_SHU_RD;
					end
				end
				S_FSUM: begin
					// fold the next entry into the previous one, then drop it
					j_q     <= i_q + 1'b1;
					state_q <= S_SHD_RD;
				end
				S_SHU_RD: begin
					if (j_q == i_q) begin
						count_q <= count_q + 1'b1;
						state_q <= S_RESP;
					end else begin
						state_q <= S_SHU_WR;
					end
				end
				S_SHU_WR: begin
					j_q     <= j_q - 1'b1;
					state_q <= S_SHU_RD;
				end
				S_RESP: begin
					// hold until the output word is free
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_addr_q   <= FW'(res_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`FSA_CHECK(a_count_range, clk, arst_n, count_q <= CW'(TABLE_DEPTH))
	`FSA_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	`FSA_CHECK(a_full_only_when_full, clk, arst_n, !(state_q == S_RESP && status_q == fsa_pkg::ST_FULL) || count_q == CW'(TABLE_DEPTH))
	`FSA_NEXT(a_reload_count, clk, arst_n, cfg_reload, count_q <= CW'(1))
endmodule
`default_nettype wire
